[rtl/smid_pkg.sv]
// ----------------------------------------------------------------------------
// smid_pkg - shared types and functions for the square marker id decoder
// Grid turning, row codeword distance and id extraction for 5x5 grids.
// ----------------------------------------------------------------------------
package smid_pkg;

    localparam int unsigned GridSide  = 5;
    localparam int unsigned GridBits  = GridSide * GridSide;
    localparam int unsigned NumRot    = 4;
    localparam int unsigned NumCode   = 4;
    localparam int unsigned RowDistW  = 3;
    localparam int unsigned SumW      = 5;
    localparam int unsigned IdW       = 10;
    localparam int unsigned RotW      = 2;

    typedef logic [GridBits-1:0]                 t_grid;
    typedef logic [GridSide-1:0]                 t_row;
    typedef logic [RowDistW-1:0]                 t_row_dist;
    typedef t_row_dist [GridSide-1:0]            t_grid_dists;
    typedef t_grid_dists [NumRot-1:0]            t_rot_dists;
    typedef logic [SumW-1:0]                     t_sum;
    typedef t_sum [NumRot-1:0]                   t_rot_sums;
    typedef logic [RotW-1:0]                     t_rot;
    typedef logic [IdW-1:0]                      t_id;

    // Codewords, column 0 in the most significant bit
    localparam t_row CODEWORDS [NumCode] = '{5'h10, 5'h17, 5'h09, 5'h0E};

    // Cell (row, col) of a grid
    function automatic logic cell_get(input t_grid g, input int unsigned r,
                                      input int unsigned c);
        return g[GridBits-1-(GridSide*r+c)];
    endfunction

    // One quarter turn: new(i,j) = old(4-j,i)
    function automatic t_grid quarter_turn(input t_grid g);
        t_grid t;
        t = '0;
        for (int unsigned i = 0; i < GridSide; i++) begin
            for (int unsigned j = 0; j < GridSide; j++) begin
                t[GridBits-1-(GridSide*i+j)] = cell_get(g, GridSide-1-j, i);
            end
        end
        return t;
    endfunction

    // Grid after n quarter turns
    function automatic t_grid grid_turn(input t_grid g, input t_rot n);
        t_grid t;
        unique case (n)
            2'd0:    t = g;
            2'd1:    t = quarter_turn(g);
            2'd2:    t = quarter_turn(quarter_turn(g));
            default: t = quarter_turn(quarter_turn(quarter_turn(g)));
        endcase
        return t;
    endfunction

    // Row y of a grid, column 0 in the most significant bit
    function automatic t_row grid_row(input t_grid g, input int unsigned y);
        return g[GridBits-1-GridSide*y -: GridSide];
    endfunction

    // Mismatch count to the nearest codeword
    function automatic t_row_dist row_dist(input t_row row);
        t_row      x;
        t_row_dist n;
        t_row_dist best;
        best = t_row_dist'(GridSide);
        for (int unsigned p = 0; p < NumCode; p++) begin
            x = row ^ CODEWORDS[p];
            n = '0;
            for (int unsigned k = 0; k < GridSide; k++) begin
                n = n + t_row_dist'(x[k]);
            end
            if (n < best) begin
                best = n;
            end
        end
        return best;
    endfunction

    // Id from columns 1 and 3, top row most significant
    function automatic t_id grid_id(input t_grid g);
        t_id v;
        v = '0;
        for (int unsigned y = 0; y < GridSide; y++) begin
            v[IdW-1-2*y]   = cell_get(g, y, 1);
            v[IdW-1-2*y-1] = cell_get(g, y, 3);
        end
        return v;
    endfunction

endpackage

[rtl/smid_row_dist.sv]
// ----------------------------------------------------------------------------
// smid_row_dist - first pipeline stage of the marker decoder
// Turns the grid four ways and registers the nearest-codeword distance of
// every row of every orientation, with the grid and its valid bit.
// ----------------------------------------------------------------------------
module smid_row_dist
    import smid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_grid       i_grid,
    output logic        o_valid,
    output t_grid       o_grid,
    output t_rot_dists  o_dists
);

    logic       r_valid;
    t_grid      r_grid;
    t_rot_dists r_dists;
    t_rot_dists n_dists;

    // Row distances for each orientation
    always_comb begin
        for (int unsigned r = 0; r < NumRot; r++) begin
            for (int unsigned y = 0; y < GridSide; y++) begin
                n_dists[r][y] = row_dist(grid_row(grid_turn(i_grid, t_rot'(r)), y));
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Hold the payload of the request
    always_ff @(posedge i_clk) begin
        r_grid  <= i_grid;
        r_dists <= n_dists;
    end

    assign o_valid = r_valid;
    assign o_grid  = r_grid;
    assign o_dists = r_dists;

endmodule

[rtl/square_marker_id_decode.sv]
// ----------------------------------------------------------------------------
// square_marker_id_decode - 5x5 square marker id decoder
// Finds the orientation of a marker grid nearest to the codeword set and
// reads its 10-bit id when the match is exact.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                         | Handshake
//  ---------+-----------------------------------------------+------------------
//  request  | i_marker_bits                                 | start, busy
//  result   | o_marker_id, o_found, o_rotation_count,       | o_valid strobe,
//           | o_best_distance                               | one cycle
//
//  Four register stages: row distances, orientation sums, best orientation,
//  id and result, each registered in turn.
//  One request is taken in every cycle; busy stays low.
//  Reset clears the valid bits only; requests in flight are dropped.
//  The receiver cannot stall, so results leave the pipeline as they arrive.
// ----------------------------------------------------------------------------
module square_marker_id_decode
    import smid_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [24:0]  i_marker_bits,
    output logic         o_valid,
    output logic [9:0]   o_marker_id,
    output logic         o_found,
    output logic [1:0]   o_rotation_count,
    output logic [4:0]   o_best_distance
);

    logic       s1_valid;
    t_grid      s1_grid;
    t_rot_dists s1_dists;

    logic       r_s2_valid;
    t_grid      r_s2_grid;
    t_rot_sums  r_s2_sums;
    t_rot_sums  n_s2_sums;

    logic       r_s3_valid;
    t_grid      r_s3_grid;
    t_rot       r_s3_rot;
    t_sum       r_s3_dist;
    t_rot       n_s3_rot;
    t_sum       n_s3_dist;

    logic       r_s4_valid;
    t_id        r_s4_id;
    logic       r_s4_found;
    t_rot       r_s4_rot;
    t_sum       r_s4_dist;
    logic       n_s4_found;

    assign busy = 1'b0;

    // Stage 1: row distances of all orientations
    smid_row_dist u_row_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_grid  (i_marker_bits),
        .o_valid (s1_valid),
        .o_grid  (s1_grid),
        .o_dists (s1_dists)
    );

    // Stage 2: sum the row distances of each orientation
    always_comb begin
        for (int unsigned r = 0; r < NumRot; r++) begin
            n_s2_sums[r] = '0;
            for (int unsigned y = 0; y < GridSide; y++) begin
                n_s2_sums[r] = n_s2_sums[r] + t_sum'(s1_dists[r][y]);
            end
        end
    end

    // Stage 3: pick the smallest sum, earliest orientation on a tie
    always_comb begin
        n_s3_rot  = '0;
        n_s3_dist = r_s2_sums[0];
        for (int unsigned r = 1; r < NumRot; r++) begin
            if (r_s2_sums[r] < n_s3_dist) begin
                n_s3_dist = r_s2_sums[r];
                n_s3_rot  = t_rot'(r);
            end
        end
    end

    // Stage 4: exact match flag
    assign n_s4_found = (r_s3_dist == '0);

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s2_valid <= s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        r_s2_grid  <= s1_grid;
        r_s2_sums  <= n_s2_sums;
        r_s3_grid  <= r_s2_grid;
        r_s3_rot   <= n_s3_rot;
        r_s3_dist  <= n_s3_dist;
        r_s4_found <= n_s4_found;
        r_s4_rot   <= r_s3_rot;
        r_s4_dist  <= r_s3_dist;
        r_s4_id    <= n_s4_found ? grid_id(grid_turn(r_s3_grid, r_s3_rot)) : '0;
    end

    assign o_valid          = r_s4_valid;
    assign o_marker_id      = r_s4_id;
    assign o_found          = r_s4_found;
    assign o_rotation_count = r_s4_rot;
    assign o_best_distance  = r_s4_dist;

endmodule

[verif/square_marker_id_decode_checker.sv]
// ----------------------------------------------------------------------------
// square_marker_id_decode_checker - result checker for the marker id decoder
// Watches the request and result ports, predicts each decode from the grid
// and compares every result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module square_marker_id_decode_checker
    import smid_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_busy,
    input  logic [24:0]  i_marker_bits,
    input  logic         i_valid,
    input  logic [9:0]   i_marker_id,
    input  logic         i_found,
    input  logic [1:0]   i_rotation_count,
    input  logic [4:0]   i_best_distance,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_id  marker_id;
        logic found;
        t_rot rotation;
        t_sum distance;
    } t_decode;

    // Row patterns, column 0 in the most significant bit
    localparam t_row MarkRows [4] = '{5'b10000, 5'b10111, 5'b01001, 5'b01110};

    t_decode decode_q[$];
    t_decode oldest;
    int      fail_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Turn the grid a quarter: cell (i,j) takes the old cell (4-j,i)
    function automatic t_grid turn_quarter(input t_grid g);
        t_grid t;
        t = '0;
        for (int i = 0; i < 5; i++) begin
            for (int j = 0; j < 5; j++) begin
                t[24-(5*i+j)] = g[24-(5*(4-j)+i)];
            end
        end
        return t;
    endfunction

    // Count mismatched cells to the nearest row pattern
    function automatic int unsigned row_miss(input t_row r);
        int unsigned least;
        int unsigned d;
        least = 5;
        for (int p = 0; p < 4; p++) begin
            d = $countones(r ^ MarkRows[p]);
            if (d < least) begin
                least = d;
            end
        end
        return least;
    endfunction

    function automatic int unsigned grid_miss(input t_grid g);
        int unsigned total;
        total = 0;
        for (int y = 0; y < 5; y++) begin
            total += row_miss(g[24-5*y -: 5]);
        end
        return total;
    endfunction

    // Collect columns 1 and 3 of every row, top row first
    function automatic t_id read_id(input t_grid g);
        t_id v;
        v = '0;
        for (int y = 0; y < 5; y++) begin
            v = {v[7:0], g[23-5*y], g[21-5*y]};
        end
        return v;
    endfunction

    // Pick the orientation with the fewest misses, keeping the earliest on ties
    function automatic t_decode decode_marker(input t_grid grid);
        t_decode     res;
        t_grid       g;
        t_grid       win_grid;
        int unsigned miss;
        int unsigned win_miss;
        g        = grid;
        win_grid = grid;
        win_miss = grid_miss(grid);
        res      = '0;
        for (int r = 1; r < 4; r++) begin
            g    = turn_quarter(g);
            miss = grid_miss(g);
            if (miss < win_miss) begin
                win_miss     = miss;
                win_grid     = g;
                res.rotation = t_rot'(r);
            end
        end
        res.distance  = t_sum'(win_miss);
        res.found     = (win_miss == 0);
        res.marker_id = res.found ? read_id(win_grid) : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Check results first, then record the request taken on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid === 1'b1) begin
                if (decode_q.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending, id %0d",
                                              i_marker_id));
                end else begin
                    oldest = decode_q.pop_front();
                    if (i_marker_id !== oldest.marker_id)
                        report_mismatch($sformatf("marker_id got %0d expected %0d",
                                                  i_marker_id, oldest.marker_id));
                    if (i_found !== oldest.found)
                        report_mismatch($sformatf("found got %0d expected %0d",
                                                  i_found, oldest.found));
                    if (i_rotation_count !== oldest.rotation)
                        report_mismatch($sformatf("rotation_count got %0d expected %0d",
                                                  i_rotation_count, oldest.rotation));
                    if (i_best_distance !== oldest.distance)
                        report_mismatch($sformatf("best_distance got %0d expected %0d",
                                                  i_best_distance, oldest.distance));
                end
            end
            if (i_start && !i_busy) begin
                decode_q.push_back(decode_marker(i_marker_bits));
            end
        end
        o_fail_count = fail_count;
        o_pending    = decode_q.size();
    end

endmodule

[verif/square_marker_id_decode_tb.sv]
// ----------------------------------------------------------------------------
// square_marker_id_decode_tb - testbench for the square marker id decoder
// Sends directed grids (extremes, exact markers in every orientation, ties,
// near misses) and then random bursts of markers and noise; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module square_marker_id_decode_tb
    import smid_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomItems = 550;
    localparam int IdleLimit   = 1000;
    localparam int DrainCycles = 10;

    localparam t_row MarkRows [4] = '{5'b10000, 5'b10111, 5'b01001, 5'b01110};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        start         = 1'b0;
    logic [24:0] i_marker_bits = '0;
    logic        busy;
    logic        o_valid;
    logic [9:0]  o_marker_id;
    logic        o_found;
    logic [1:0]  o_rotation_count;
    logic [4:0]  o_best_distance;
    int          fail_count;
    int          pending;
    int          idle_cycles   = 0;

    always #5 i_clk = ~i_clk;

    square_marker_id_decode dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_marker_bits    (i_marker_bits),
        .o_valid          (o_valid),
        .o_marker_id      (o_marker_id),
        .o_found          (o_found),
        .o_rotation_count (o_rotation_count),
        .o_best_distance  (o_best_distance)
    );

    square_marker_id_decode_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_marker_bits    (i_marker_bits),
        .i_valid          (o_valid),
        .i_marker_id      (o_marker_id),
        .i_found          (o_found),
        .i_rotation_count (o_rotation_count),
        .i_best_distance  (o_best_distance),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Turn a grid n quarter turns to place a marker in another orientation
    function automatic t_grid spin_grid(input t_grid g, input int n);
        t_grid t;
        for (int k = 0; k < n; k++) begin
            t = '0;
            for (int i = 0; i < 5; i++) begin
                for (int j = 0; j < 5; j++) begin
                    t[24-(5*i+j)] = g[24-(5*(4-j)+i)];
                end
            end
            g = t;
        end
        return g;
    endfunction

    // Build an exact marker from random row patterns, then turn it
    function automatic t_grid build_marker(input int turns);
        t_grid g;
        g = '0;
        for (int y = 0; y < 5; y++) begin
            g = {g[19:0], MarkRows[$urandom_range(0, 3)]};
        end
        return spin_grid(g, turns);
    endfunction

    // Present one request and hold it until taken
    task automatic send_marker(input t_grid g);
        @(negedge i_clk);
        start         <= 1'b1;
        i_marker_bits <= g;
        do @(posedge i_clk); while (busy);
    endtask

    // Drop start for a number of cycles, with noise on the data port
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_marker_bits <= 25'($urandom());
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Hold off until every pending request has produced its result
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_grid g;
        t_grid fixed;
        int    sel;
        int    burst_left;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, patterns, exact markers in each orientation
        fixed = {5'b10000, 5'b10111, 5'b01001, 5'b01110, 5'b10000};
        send_marker(25'h0000000);
        send_marker(25'h1FFFFFF);
        send_marker(25'h1555555);
        send_marker(25'h0AAAAAA);
        for (int k = 0; k < 4; k++) begin
            send_marker(spin_grid(fixed, k));
        end
        // All rows 01110 gives the largest id, all rows 10000 gives zero
        send_marker({5{5'b01110}});
        send_marker({5{5'b10000}});
        send_marker(spin_grid({5{5'b10111}}, 1));
        send_marker({5{5'b01001}});
        // Near misses: one, two and many flipped cells
        send_marker(fixed ^ 25'h0000001);
        send_marker(spin_grid(fixed, 2) ^ 25'h1000000);
        send_marker(fixed ^ 25'h0401000);
        send_marker({5{5'b11011}});
        send_marker({5{5'b00110}});
        // Symmetric grids tie across orientations
        send_marker(25'h0421084);
        send_marker(25'h00E7380);
        for (int k = 0; k < 4; k++) begin
            send_marker(build_marker(k));
        end
        drain_results();

        // Random: mostly exact markers, some near misses, some noise
        burst_left = $urandom_range(1, 30);
        for (int n = 0; n < RandomItems; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                g = build_marker($urandom_range(0, 3));
            end else if (sel < 8) begin
                g = build_marker($urandom_range(0, 3));
                repeat ($urandom_range(1, 3)) g[$urandom_range(0, 24)] ^= 1'b1;
            end else begin
                g = 25'($urandom());
            end
            send_marker(g);
            if (n == RandomItems / 2) begin
                drain_results();
            end
            burst_left--;
            if (burst_left == 0) begin
                pause_sender($urandom_range(0, 12));
                burst_left = $urandom_range(1, 30);
            end
        end

        drain_results();
        repeat (DrainCycles) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/smid_pkg.sv
rtl/smid_row_dist.sv
rtl/square_marker_id_decode.sv
verif/square_marker_id_decode_checker.sv
verif/square_marker_id_decode_tb.sv
